// ----- rtl/lrb_pkg.sv -----
// Shared types and codes for the link reconnect backoff supervisor.
`timescale 1ns / 1ps

package lrb_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_POLL_INTERVAL   = 2'd0;
    localparam logic [1:0] CFG_CONNECT_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_BACKOFF_MIN     = 2'd2;
    localparam logic [1:0] CFG_BACKOFF_MAX     = 2'd3;

    // Register reset values in ms
    localparam logic [31:0] POLL_INTERVAL_RST   = 32'd500;
    localparam logic [31:0] CONNECT_TIMEOUT_RST = 32'd15000;
    localparam logic [31:0] BACKOFF_MIN_RST     = 32'd1000;
    localparam logic [31:0] BACKOFF_MAX_RST     = 32'd60000;

    // Request modes
    localparam logic MODE_POLL  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // Event codes
    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_CONNECTED = 2'd1;
    localparam logic [1:0] EV_TIMEOUT   = 2'd2;
    localparam logic [1:0] EV_LOST      = 2'd3;

    typedef struct packed {
        logic [31:0] poll_interval;
        logic [31:0] connect_timeout;
        logic [31:0] backoff_min;
        logic [31:0] backoff_max;
    } t_cfg;

    typedef struct packed {
        logic        mode;
        logic [31:0] now_ms;
        logic        link_up;
    } t_item;

    typedef struct packed {
        logic [1:0] link_state;
        logic       start_connect;
        logic       time_sync_start;
        logic [1:0] event_res;
        logic       polled;
    } t_result;

endpackage

// ----- rtl/lrb_cfg.sv -----
// Configuration register file for the reconnect supervisor.
`timescale 1ns / 1ps

module lrb_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    output lrb_pkg::t_cfg o_cfg
);
    import lrb_pkg::*;

    t_cfg r_cfg;

    // Write one register per enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval   <= POLL_INTERVAL_RST;
            r_cfg.connect_timeout <= CONNECT_TIMEOUT_RST;
            r_cfg.backoff_min     <= BACKOFF_MIN_RST;
            r_cfg.backoff_max     <= BACKOFF_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLL_INTERVAL:   r_cfg.poll_interval   <= i_cfg_data;
                CFG_CONNECT_TIMEOUT: r_cfg.connect_timeout <= i_cfg_data;
                CFG_BACKOFF_MIN:     r_cfg.backoff_min     <= i_cfg_data;
                CFG_BACKOFF_MAX:     r_cfg.backoff_max     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/lrb_step.sv -----
// Connection state machine with backoff scheduling, one request per enable.
`timescale 1ns / 1ps

module lrb_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  lrb_pkg::t_item   i_item,
    input  lrb_pkg::t_cfg    i_cfg,
    output lrb_pkg::t_result o_res
);
    import lrb_pkg::*;

    typedef enum logic [1:0] {
        PH_DISC       = 2'd0,
        PH_CONNECTING = 2'd1,
        PH_CONNECTED  = 2'd2
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [31:0] r_attempt, n_attempt;
    logic [31:0] r_next,    n_next;
    logic [31:0] r_last,    n_last;
    logic [31:0] r_backoff, n_backoff;
    logic        r_synced,  n_synced;

    logic [31:0] poll_gap, attempt_age, due_gap, doubled, widened;
    logic        gate_open;
    t_result     res;

    // Wrapping time differences
    assign poll_gap    = i_item.now_ms - r_last;
    assign attempt_age = i_item.now_ms - r_attempt;
    assign due_gap     = i_item.now_ms - r_next;
    assign gate_open   = (poll_gap >= i_cfg.poll_interval);

    // Doubled backoff, saturating, then capped
    assign doubled = r_backoff[31] ? '1 : {r_backoff[30:0], 1'b0};
    assign widened = (doubled < i_cfg.backoff_max) ? doubled : i_cfg.backoff_max;

    // Next state and result
    always_comb begin
        n_phase   = r_phase;
        n_attempt = r_attempt;
        n_next    = r_next;
        n_last    = r_last;
        n_backoff = r_backoff;
        n_synced  = r_synced;
        res       = '0;
        if (i_item.mode == MODE_START) begin
            n_backoff = i_cfg.backoff_min;
            n_next    = i_item.now_ms;
        end else if (gate_open) begin
            res.polled = 1'b1;
            n_last     = i_item.now_ms;
            case (r_phase)
                PH_CONNECTING: begin
                    if (i_item.link_up) begin
                        n_phase       = PH_CONNECTED;
                        n_backoff     = i_cfg.backoff_min;
                        res.event_res = EV_CONNECTED;
                        if (!r_synced) begin
                            n_synced            = 1'b1;
                            res.time_sync_start = 1'b1;
                        end
                    end else if (attempt_age >= i_cfg.connect_timeout) begin
                        res.event_res = EV_TIMEOUT;
                        n_phase       = PH_DISC;
                        n_next        = i_item.now_ms + r_backoff;
                        n_backoff     = widened;
                    end
                end
                PH_CONNECTED: begin
                    if (!i_item.link_up) begin
                        res.event_res = EV_LOST;
                        n_phase       = PH_DISC;
                        n_next        = i_item.now_ms + r_backoff;
                        n_backoff     = widened;
                    end
                end
                default: begin
                    if (!due_gap[31]) begin
                        n_phase           = PH_CONNECTING;
                        n_attempt         = i_item.now_ms;
                        res.start_connect = 1'b1;
                    end
                end
            endcase
        end
        res.link_state = n_phase;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_DISC;
            r_attempt <= '0;
            r_next    <= '0;
            r_last    <= '0;
            r_backoff <= BACKOFF_MIN_RST;
            r_synced  <= 1'b0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_attempt <= n_attempt;
            r_next    <= n_next;
            r_last    <= n_last;
            r_backoff <= n_backoff;
            r_synced  <= n_synced;
        end
    end

    assign o_res = res;

    // Time sync pulses only once
    a_sync_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_synced |-> !res.time_sync_start)
        else $error("time sync start repeated");

    // An attempt starts only from disconnected on an evaluated poll
    a_start_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.start_connect |-> (r_phase == PH_DISC) && res.polled)
        else $error("attempt started outside disconnected phase");

    // Connected event lands in the connected phase and resets backoff
    a_conn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && res.event_res == EV_CONNECTED) |=>
            (r_phase == PH_CONNECTED) && (r_backoff == $past(i_cfg.backoff_min)))
        else $error("connect did not settle state");

    // A drop always returns to disconnected
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (res.event_res == EV_TIMEOUT || res.event_res == EV_LOST)) |=>
            (r_phase == PH_DISC))
        else $error("drop did not disconnect");

endmodule

// ----- rtl/link_reconnect_backoff_fsm_core.sv -----
// Link reconnect supervisor: input register, state step, result register.
// A request waits in the input register until the result register is free or being
// taken, then is evaluated into the result register, which drives o_valid.
// Throughput: one request per cycle unless i_ready stalls; one combinational step.
// Reset (i_rst_n low, synchronous): both stages empty, phase disconnected, times zero,
// backoff and configuration registers at their default values.
`timescale 1ns / 1ps

module link_reconnect_backoff_fsm_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [31:0] i_now_ms,
    input  logic        i_link_up,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_link_state,
    output logic        o_start_connect,
    output logic        o_time_sync_start,
    output logic [1:0]  o_event_res,
    output logic        o_polled
);
    import lrb_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result step_res;
    t_result r_res;
    logic    r_out_valid;
    logic    advance;

    lrb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Request moves on when the result slot is free or being taken
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.mode    <= i_mode;
            r_item.now_ms  <= i_now_ms;
            r_item.link_up <= i_link_up;
        end
    end

    lrb_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_link_state      = r_res.link_state;
    assign o_start_connect   = r_res.start_connect;
    assign o_time_sync_start = r_res.time_sync_start;
    assign o_event_res       = r_res.event_res;
    assign o_polled          = r_res.polled;

endmodule

// ----- dv/lrb_status_checker.sv -----
// Checker for the link reconnect supervisor: predicts each response and compares it.
`timescale 1ns / 1ps

module lrb_status_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_mode,
    input  logic [31:0] i_now_ms,
    input  logic        i_link_up,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [1:0]  i_link_state,
    input  logic        i_start_connect,
    input  logic        i_time_sync_start,
    input  logic [1:0]  i_event_res,
    input  logic        i_polled,
    output int          o_fail_count,
    output int          o_pending
);
    import lrb_pkg::*;

    typedef enum logic [1:0] {
        LINK_DOWN     = 2'd0,
        LINK_DIALLING = 2'd1,
        LINK_UP       = 2'd2
    } t_link;

    // Shadow copy of the registers and of the supervisor state
    t_cfg        cfg;
    t_link       link_phase;
    logic [31:0] dial_start;
    logic [31:0] retry_at;
    logic [31:0] last_eval;
    logic [31:0] backoff;
    logic        synced;

    t_result     status_q[$];
    int          fails = 0;
    int          rsp_count = 0;

    assign o_fail_count = fails;

    // Drop to disconnected, book the retry and widen the backoff
    function automatic void schedule_retry(input logic [31:0] now);
        logic [31:0] dbl;
        link_phase = LINK_DOWN;
        retry_at   = now + backoff;
        dbl        = backoff[31] ? 32'hFFFF_FFFF : {backoff[30:0], 1'b0};
        backoff    = (dbl < cfg.backoff_max) ? dbl : cfg.backoff_max;
    endfunction

    // One request through the supervisor; returns the status it should report
    function automatic t_result advance_link(input t_item req);
        t_result     res;
        logic [31:0] since;
        res = '0;
        if (req.mode == MODE_START) begin
            backoff  = cfg.backoff_min;
            retry_at = req.now_ms;
        end else begin
            since = req.now_ms - last_eval;
            if (since >= cfg.poll_interval) begin
                res.polled = 1'b1;
                last_eval  = req.now_ms;
                case (link_phase)
                    LINK_DIALLING: begin
                        if (req.link_up) begin
                            link_phase    = LINK_UP;
                            backoff       = cfg.backoff_min;
                            res.event_res = EV_CONNECTED;
                            if (!synced) begin
                                synced              = 1'b1;
                                res.time_sync_start = 1'b1;
                            end
                        end else begin
                            since = req.now_ms - dial_start;
                            if (since >= cfg.connect_timeout) begin
                                res.event_res = EV_TIMEOUT;
                                schedule_retry(req.now_ms);
                            end
                        end
                    end
                    LINK_UP: begin
                        if (!req.link_up) begin
                            res.event_res = EV_LOST;
                            schedule_retry(req.now_ms);
                        end
                    end
                    default: begin
                        // due once the wrapped distance to the retry time is non-negative
                        since = req.now_ms - retry_at;
                        if (!since[31]) begin
                            link_phase        = LINK_DIALLING;
                            dial_start        = req.now_ms;
                            res.start_connect = 1'b1;
                        end
                    end
                endcase
            end
        end
        res.link_state = link_phase;
        return res;
    endfunction

    // Watch both channels and the register port
    always @(posedge i_clk) begin : watch
        t_item   req;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg.poll_interval   = POLL_INTERVAL_RST;
            cfg.connect_timeout = CONNECT_TIMEOUT_RST;
            cfg.backoff_min     = BACKOFF_MIN_RST;
            cfg.backoff_max     = BACKOFF_MAX_RST;
            link_phase          = LINK_DOWN;
            dial_start          = '0;
            retry_at            = '0;
            last_eval           = '0;
            backoff             = BACKOFF_MIN_RST;
            synced              = 1'b0;
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLL_INTERVAL:   cfg.poll_interval   = i_cfg_data;
                    CFG_CONNECT_TIMEOUT: cfg.connect_timeout = i_cfg_data;
                    CFG_BACKOFF_MIN:     cfg.backoff_min     = i_cfg_data;
                    default:             cfg.backoff_max     = i_cfg_data;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                req.mode    = i_mode;
                req.now_ms  = i_now_ms;
                req.link_up = i_link_up;
                status_q.push_back(advance_link(req));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got.link_state      = i_link_state;
                got.start_connect   = i_start_connect;
                got.time_sync_start = i_time_sync_start;
                got.event_res       = i_event_res;
                got.polled          = i_polled;
                rsp_count++;
                if (status_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("response %0d arrived with no request outstanding",
                                 rsp_count);
                end else begin
                    want = status_q.pop_front();
                    if (got.link_state      !== want.link_state    ||
                        got.start_connect   !== want.start_connect ||
                        got.time_sync_start !== want.time_sync_start ||
                        got.event_res       !== want.event_res     ||
                        got.polled          !== want.polled) begin
                        fails++;
                        if (fails <= 10)
                            $display({"response %0d mismatch: expected state %0d start %0b",
                                      " sync %0b event %0d polled %0b, got state %0d",
                                      " start %0b sync %0b event %0d polled %0b"},
                                     rsp_count, want.link_state, want.start_connect,
                                     want.time_sync_start, want.event_res, want.polled,
                                     got.link_state, got.start_connect,
                                     got.time_sync_start, got.event_res, got.polled);
                    end
                end
            end
        end
        o_pending = status_q.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the link reconnect supervisor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import lrb_pkg::*;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = CFG_POLL_INTERVAL;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid    = 1'b0;
    logic        i_mode     = MODE_POLL;
    logic [31:0] i_now_ms   = '0;
    logic        i_link_up  = 1'b0;
    logic        i_ready    = 1'b0;

    wire         o_ready;
    wire         o_valid;
    wire [1:0]   o_link_state;
    wire         o_start_connect;
    wire         o_time_sync_start;
    wire [1:0]   o_event_res;
    wire         o_polled;

    int          status_fails;
    int          status_pending;

    // Request side bookkeeping
    int          reqs_sent  = 0;
    int          burst_left = 1;
    logic [31:0] wall_ms    = '0;
    logic        link_model = 1'b0;

    link_reconnect_backoff_fsm_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_now_ms          (i_now_ms),
        .i_link_up         (i_link_up),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_link_state      (o_link_state),
        .o_start_connect   (o_start_connect),
        .o_time_sync_start (o_time_sync_start),
        .o_event_res       (o_event_res),
        .o_polled          (o_polled)
    );

    lrb_status_checker u_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_req_valid       (i_valid),
        .i_req_ready       (o_ready),
        .i_mode            (i_mode),
        .i_now_ms          (i_now_ms),
        .i_link_up         (i_link_up),
        .i_rsp_valid       (o_valid),
        .i_rsp_ready       (i_ready),
        .i_link_state      (o_link_state),
        .i_start_connect   (o_start_connect),
        .i_time_sync_start (o_time_sync_start),
        .i_event_res       (o_event_res),
        .i_polled          (o_polled),
        .o_fail_count      (status_fails),
        .o_pending         (status_pending)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Response side: stall patterns, plus one long hold-off to back the block up
    initial begin : rx_pace
        int style;
        int seg;
        bit held;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            style = $urandom_range(0, 3);
            seg   = $urandom_range(4, 64);
            if (!held && reqs_sent >= 150) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            repeat (seg) begin
                case (style)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    2:       i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ~i_ready;
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Offer one request and hold it until taken; gaps come between bursts
    task automatic send_req(input logic mode, input logic [31:0] now, input logic up);
        int gap;
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_now_ms  <= now;
        i_link_up <= up;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        reqs_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Mostly a time-ordered poll stream with a wandering link; some starts and noise
    task automatic send_random(input logic [31:0] step_cap);
        if ($urandom_range(0, 7) == 0) link_model = ~link_model;
        wall_ms = wall_ms + $urandom_range(0, step_cap);
        case ($urandom_range(0, 19))
            0:       send_req(MODE_START, wall_ms, 1'($urandom_range(0, 1)));
            1:       send_req(MODE_POLL, $urandom(), 1'($urandom_range(0, 1)));
            default: send_req(MODE_POLL, wall_ms, link_model);
        endcase
    endtask

    // Stop offering and wait until every response is back
    task automatic settle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (status_pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] pi, input logic [31:0] ct,
                                input logic [31:0] bmin, input logic [31:0] bmax);
        write_reg(CFG_POLL_INTERVAL, pi);
        write_reg(CFG_CONNECT_TIMEOUT, ct);
        write_reg(CFG_BACKOFF_MIN, bmin);
        write_reg(CFG_BACKOFF_MAX, bmax);
        i_cfg_we <= 1'b0;
    endtask

    // Main sequence
    initial begin : stim
        logic [31:0] pi;
        logic [31:0] ct;
        logic [31:0] bmin;
        logic [31:0] bmax;
        logic [31:0] step_cap;
        int          n_reqs;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk at the reset register values
        send_req(MODE_POLL,  32'd0,          1'b0); // gated: no time since last poll
        send_req(MODE_START, 32'hFFFF_FFFF,  1'b1); // start while disconnected
        send_req(MODE_POLL,  32'd499,        1'b0); // one short of the interval
        send_req(MODE_POLL,  32'd500,        1'b0); // due across the wrap: dial
        send_req(MODE_POLL,  32'd1000,       1'b0); // still dialling
        send_req(MODE_POLL,  32'd15500,      1'b0); // timeout exactly at the limit
        send_req(MODE_POLL,  32'd16000,      1'b1); // retry not yet due
        send_req(MODE_POLL,  32'd16500,      1'b1); // retry due: dial
        send_req(MODE_POLL,  32'd17000,      1'b1); // first connection: sync pulse
        send_req(MODE_POLL,  32'd17500,      1'b1); // steady
        send_req(MODE_POLL,  32'd18000,      1'b0); // link lost
        send_req(MODE_POLL,  32'd19000,      1'b0); // redial
        send_req(MODE_POLL,  32'd34000,      1'b0); // timeout, backoff widens
        send_req(MODE_START, 32'd34100,      1'b0); // start resets backoff
        send_req(MODE_POLL,  32'd34600,      1'b1); // dial at once
        send_req(MODE_POLL,  32'd35100,      1'b1); // reconnect, no second sync
        send_req(MODE_START, 32'd35200,      1'b0); // start while connected
        send_req(MODE_POLL,  32'h7FFF_FFFF,  1'b1); // steady, far ahead
        send_req(MODE_POLL,  32'hFFFF_FFFF,  1'b1); // top of the clock
        send_req(MODE_POLL,  32'h0000_01F3,  1'b0); // lost just after wrap
        send_req(MODE_POLL,  32'h8000_0000,  1'b0); // half-range distance, still due
        settle();

        // Register settings, extremes first, then random ones
        for (int p = 0; p < 11; p++) begin
            n_reqs   = 150;
            wall_ms  = $urandom();
            case (p)
                0: begin
                    pi = 10; ct = 200; bmin = 50; bmax = 1000;
                    step_cap = 40; n_reqs = 400;
                end
                1: begin
                    pi = 0; ct = 0; bmin = 0; bmax = 0;
                    step_cap = 5;
                end
                2: begin
                    pi = 1; ct = 32'hFFFF_FFFF; bmin = 32'h8000_0001; bmax = 32'hFFFF_FFFF;
                    step_cap = 32'hFFFF_FFFF;
                end
                3: begin
                    pi = 32'hFFFF_FFFF; ct = 100; bmin = 10; bmax = 40;
                    step_cap = 32'hFFFF_FFFF; n_reqs = 40;
                end
                4: begin
                    // floor above the ceiling
                    pi = 5; ct = 60; bmin = 5000; bmax = 100;
                    step_cap = 30; n_reqs = 200;
                end
                5: begin
                    // run the clock across the wrap
                    pi = 4; ct = 80; bmin = 16; bmax = 500;
                    step_cap = 25; n_reqs = 300;
                    wall_ms = 32'hFFFF_F000 + $urandom_range(0, 2048);
                end
                10: begin
                    pi = $urandom(); ct = $urandom(); bmin = $urandom(); bmax = $urandom();
                    step_cap = 32'hFFFF_FFFF; n_reqs = 60;
                end
                default: begin
                    pi   = $urandom_range(0, 40);
                    ct   = $urandom_range(0, 400);
                    bmin = $urandom_range(0, 300);
                    bmax = $urandom_range(0, 3000);
                    step_cap = 2 * pi + ct / 8 + 10;
                end
            endcase
            program_regs(pi, ct, bmin, bmax);
            repeat (n_reqs) send_random(step_cap);
            settle();
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (status_fails == 0 && status_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lrb_pkg.sv
rtl/lrb_cfg.sv
rtl/lrb_step.sv
rtl/link_reconnect_backoff_fsm_core.sv
dv/lrb_status_checker.sv
dv/tb.sv
